// ----- sv/stunrc_pkg.sv -----
// Package for the STUN request checker: constants, walk phase codes,
// result record and ufrag character select. No dependencies.
`default_nettype none

package stunrc_pkg;

  localparam int unsigned MAX_UFRAG = 16;

  localparam logic [4:0]  HDR_BYTES    = 5'd20;
  localparam logic [31:0] COOKIE_MAGIC = 32'h2112_A442;
  localparam logic [15:0] REQ_BINDING  = 16'h0001;
  localparam logic [15:0] ATTR_USER    = 16'h0006;
  localparam logic [7:0]  CHAR_COLON   = 8'h3A;
  localparam logic [16:0] POS_LIMIT    = 17'h1FFFF;

  localparam logic [1:0] CLASS_STUN  = 2'd0;
  localparam logic [1:0] CLASS_DTLS  = 2'd1;
  localparam logic [1:0] CLASS_RTP   = 2'd2;
  localparam logic [1:0] CLASS_OTHER = 2'd3;

  localparam logic [1:0] PH_WALKING  = 2'd0;
  localparam logic [1:0] PH_MATCHING = 2'd1;
  localparam logic [1:0] PH_MISS     = 2'd2;
  localparam logic [1:0] PH_FOUND    = 2'd3;

  localparam logic [1:0] REG_UFRAG_LEN  = 2'd0;
  localparam logic [1:0] REG_CHARS_LOW  = 2'd1;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0]  packet_class;
    logic        is_binding_request;
    logic        username_matches;
    logic [31:0] transaction_id_high;
    logic [63:0] transaction_id_low;
  } res_t;

  function automatic logic [7:0] ufrag_char(input logic [63:0] chars_lo,
                                            input logic [63:0] chars_hi,
                                            input logic [3:0]  idx);
    logic [63:0] word;
    word = idx[3] ? chars_hi : chars_lo;
    return word[63 - 8 * idx[2:0] -: 8];
  endfunction

endpackage

`default_nettype wire

// ----- sv/stun_request_checker.sv -----
// STUN binding request checker, top level.
// Depends on stunrc_pkg for constants, phase codes and the result record.
// Takes one datagram byte per cycle while in_stall is low; each accepted byte
// updates the header fields and the attribute walk directly in the state
// registers, so a new request can enter right after the last byte of the one
// before. On the last byte the classification is registered in the result
// register, which drives the out_ ports, or in the skid register behind it,
// which keeps requests flowing while a result is held; in_stall is high only while that skid is full.
// Sustained rate: one byte per clock while in_stall is low.
`default_nettype none

module stun_request_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_packet_class,
  output logic             out_is_binding_request,
  output logic             out_username_matches,
  output logic [31:0]      out_transaction_id_high,
  output logic [63:0]      out_transaction_id_low
);

  logic [4:0]  ufrag_len_r;
  logic [63:0] chars_lo_r;
  logic [63:0] chars_hi_r;

  logic [16:0] pos_r, pos_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [15:0] htype_r, htype_nxt;
  logic [15:0] msg_len_r, msg_len_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic [31:0] tx_hi_r, tx_hi_nxt;
  logic [63:0] tx_lo_r, tx_lo_nxt;
  logic [16:0] attr_start_r, attr_start_nxt;
  logic [15:0] attr_type_r, attr_type_nxt;
  logic [15:0] attr_size_r, attr_size_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        prefix_eq_r, prefix_eq_nxt;
  logic        sep_r, sep_nxt;

  stunrc_pkg::res_t out_r, sk_r, res;
  logic             out_valid_r, sk_valid_r;

  logic        in_acc, new_res, out_take, out_free;
  logic [17:0] pos18, start_p4, msg_stop, attr_end, start_adv, match_idx;
  logic [1:0]  rel;
  logic [15:0] len_new;
  logic [16:0] count;
  logic [17:0] need;
  logic        fits;

  assign in_stall  = sk_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign new_res   = in_acc && in_last_byte;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || out_take;

  assign pos18     = {1'b0, pos_r};
  assign start_p4  = {1'b0, attr_start_r} + 18'd4;
  assign msg_stop  = {13'd0, stunrc_pkg::HDR_BYTES} + {2'd0, msg_len_r};
  assign rel       = pos_r[1:0] - attr_start_r[1:0];
  assign len_new   = {attr_size_r[7:0], in_byte_value};
  assign attr_end  = start_p4 + {2'd0, len_new};
  assign start_adv = start_p4 + {2'd0, ((len_new + 16'd3) & ~16'd3)};
  assign match_idx = pos18 - start_p4;

  always_comb begin
    pos_nxt        = (pos_r == stunrc_pkg::POS_LIMIT) ? pos_r : pos_r + 17'd1;
    first_nxt      = first_r;
    htype_nxt      = htype_r;
    msg_len_nxt    = msg_len_r;
    cookie_nxt     = cookie_r;
    tx_hi_nxt      = tx_hi_r;
    tx_lo_nxt      = tx_lo_r;
    attr_start_nxt = attr_start_r;
    attr_type_nxt  = attr_type_r;
    attr_size_nxt  = attr_size_r;
    phase_nxt      = phase_r;
    prefix_eq_nxt  = prefix_eq_r;
    sep_nxt        = sep_r;

    if (pos_r == 17'd0) begin
      first_nxt = in_byte_value;
    end
    if (pos_r < 17'd2) begin
      htype_nxt = {htype_r[7:0], in_byte_value};
    end else if (pos_r < 17'd4) begin
      msg_len_nxt = {msg_len_r[7:0], in_byte_value};
    end else if (pos_r < 17'd8) begin
      cookie_nxt = {cookie_r[23:0], in_byte_value};
    end else if (pos_r < 17'd12) begin
      tx_hi_nxt = {tx_hi_r[23:0], in_byte_value};
    end else if (pos_r < {12'd0, stunrc_pkg::HDR_BYTES}) begin
      tx_lo_nxt = {tx_lo_r[55:0], in_byte_value};
    end else begin
      unique case (phase_r)
        stunrc_pkg::PH_WALKING: begin
          if (pos_r >= attr_start_r && pos18 < start_p4) begin
            if (rel < 2'd2) begin
              attr_type_nxt = {attr_type_r[7:0], in_byte_value};
            end else begin
              attr_size_nxt = len_new;
            end
            if (rel == 2'd3) begin
              if (start_p4 > msg_stop || attr_end > msg_stop) begin
                phase_nxt = stunrc_pkg::PH_MISS;
              end else if (attr_type_r == stunrc_pkg::ATTR_USER) begin
                if ({27'd0, ufrag_len_r} > stunrc_pkg::MAX_UFRAG ||
                    len_new <= {11'd0, ufrag_len_r}) begin
                  phase_nxt = stunrc_pkg::PH_MISS;
                end else begin
                  phase_nxt = stunrc_pkg::PH_MATCHING;
                end
              end else begin
                attr_start_nxt = start_adv[16:0];
              end
            end
          end
        end
        stunrc_pkg::PH_MATCHING: begin
          if (pos18 >= start_p4) begin
            if (match_idx < {13'd0, ufrag_len_r}) begin
              if (in_byte_value != stunrc_pkg::ufrag_char(chars_lo_r, chars_hi_r,
                                                          match_idx[3:0])) begin
                prefix_eq_nxt = 1'b0;
              end
            end else if (match_idx == {13'd0, ufrag_len_r}) begin
              sep_nxt   = (in_byte_value == stunrc_pkg::CHAR_COLON);
              phase_nxt = stunrc_pkg::PH_FOUND;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign count = pos_nxt;
  assign need  = {2'd0, msg_len_nxt} + {13'd0, stunrc_pkg::HDR_BYTES};
  assign fits  = (count >= {12'd0, stunrc_pkg::HDR_BYTES}) && (need <= {1'b0, count});

  always_comb begin
    if (first_nxt <= 8'd3) begin
      res.packet_class = stunrc_pkg::CLASS_STUN;
    end else if (first_nxt >= 8'd20 && first_nxt <= 8'd63) begin
      res.packet_class = stunrc_pkg::CLASS_DTLS;
    end else if (first_nxt >= 8'd128 && first_nxt <= 8'd191) begin
      res.packet_class = stunrc_pkg::CLASS_RTP;
    end else begin
      res.packet_class = stunrc_pkg::CLASS_OTHER;
    end
    res.is_binding_request = fits && (htype_nxt == stunrc_pkg::REQ_BINDING) &&
                             (cookie_nxt == stunrc_pkg::COOKIE_MAGIC);
    res.username_matches   = fits && (phase_nxt == stunrc_pkg::PH_FOUND) &&
                             prefix_eq_nxt && sep_nxt;
    res.transaction_id_high = res.is_binding_request ? tx_hi_nxt : 32'd0;
    res.transaction_id_low  = res.is_binding_request ? tx_lo_nxt : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ufrag_len_r <= 5'd0;
      chars_lo_r  <= 64'd0;
      chars_hi_r  <= 64'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        stunrc_pkg::REG_UFRAG_LEN:  ufrag_len_r <= cfg_wr_data[4:0];
        stunrc_pkg::REG_CHARS_LOW:  chars_lo_r  <= cfg_wr_data;
        stunrc_pkg::REG_CHARS_HIGH: chars_hi_r  <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || new_res) begin
      pos_r        <= 17'd0;
      first_r      <= 8'd0;
      htype_r      <= 16'd0;
      msg_len_r    <= 16'd0;
      cookie_r     <= 32'd0;
      tx_hi_r      <= 32'd0;
      tx_lo_r      <= 64'd0;
      attr_start_r <= {12'd0, stunrc_pkg::HDR_BYTES};
      attr_type_r  <= 16'd0;
      attr_size_r  <= 16'd0;
      phase_r      <= stunrc_pkg::PH_WALKING;
      prefix_eq_r  <= 1'b1;
      sep_r        <= 1'b0;
    end else if (in_acc) begin
      pos_r        <= pos_nxt;
      first_r      <= first_nxt;
      htype_r      <= htype_nxt;
      msg_len_r    <= msg_len_nxt;
      cookie_r     <= cookie_nxt;
      tx_hi_r      <= tx_hi_nxt;
      tx_lo_r      <= tx_lo_nxt;
      attr_start_r <= attr_start_nxt;
      attr_type_r  <= attr_type_nxt;
      attr_size_r  <= attr_size_nxt;
      phase_r      <= phase_nxt;
      prefix_eq_r  <= prefix_eq_nxt;
      sep_r        <= sep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_valid_r  <= 1'b0;
    end else if (out_free) begin
      if (sk_valid_r) begin
        out_valid_r <= 1'b1;
        sk_valid_r  <= new_res;
      end else begin
        out_valid_r <= new_res;
      end
    end else if (new_res) begin
      sk_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (sk_valid_r) begin
        out_r <= sk_r;
        sk_r  <= res;
      end else begin
        out_r <= res;
      end
    end else if (new_res) begin
      sk_r <= res;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_packet_class        = out_r.packet_class;
  assign out_is_binding_request  = out_r.is_binding_request;
  assign out_username_matches    = out_r.username_matches;
  assign out_transaction_id_high = out_r.transaction_id_high;
  assign out_transaction_id_low  = out_r.transaction_id_low;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_valid_r |-> out_valid_r)
    else $error("skid holds a request while the result register is empty");

  a_held_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    new_res |=> (pos_r == 17'd0 && phase_r == stunrc_pkg::PH_WALKING))
    else $error("packet state not cleared after last byte");

  a_request_is_stun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.is_binding_request) |->
      (out_r.packet_class == stunrc_pkg::CLASS_STUN))
    else $error("binding request with non-STUN class");

endmodule

`default_nettype wire

// ----- tb/stun_request_monitor.sv -----
`timescale 1ns / 1ps
// Monitor for the STUN request checker: tracks ufrag register writes, predicts
// the verdict of each datagram from its bytes and compares it with the output.
// Depends on stunrc_pkg for constants, walk phase codes and the result record.

module stun_request_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_packet_class,
  input  logic        out_is_binding_request,
  input  logic        out_username_matches,
  input  logic [31:0] out_transaction_id_high,
  input  logic [63:0] out_transaction_id_low,
  output int unsigned failures,
  output int unsigned awaited
);

  logic [4:0]  frag_len;
  logic [63:0] frag_lo;
  logic [63:0] frag_hi;

  logic [16:0] seen_count;
  logic [7:0]  lead_byte;
  logic [15:0] msg_type;
  logic [15:0] msg_len;
  logic [31:0] cookie;
  logic [31:0] txn_hi;
  logic [63:0] txn_lo;
  logic [16:0] attr_at;
  logic [15:0] attr_kind;
  logic [15:0] attr_size;
  logic [1:0]  walk;
  logic        chars_ok;
  logic        colon_ok;

  stunrc_pkg::res_t awaited_verdicts[$];
  int unsigned fail_tally = 0;

  task automatic clear_datagram();
    seen_count = '0;
    lead_byte  = '0;
    msg_type   = '0;
    msg_len    = '0;
    cookie     = '0;
    txn_hi     = '0;
    txn_lo     = '0;
    attr_at    = {12'd0, stunrc_pkg::HDR_BYTES};
    attr_kind  = '0;
    attr_size  = '0;
    walk       = stunrc_pkg::PH_WALKING;
    chars_ok   = 1'b1;
    colon_ok   = 1'b0;
  endtask

  function automatic logic [7:0] frag_char(input int unsigned idx);
    logic [63:0] word;
    word = (idx < 8) ? frag_lo : frag_hi;
    return word[8 * (7 - idx % 8) +: 8];
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic last);
    int unsigned p, astart, rel, idx, stop, count;
    logic fits;
    stunrc_pkg::res_t v;
    p = seen_count;
    if (p == 0) lead_byte = b;
    if (p < 2) msg_type = {msg_type[7:0], b};
    else if (p < 4) msg_len = {msg_len[7:0], b};
    else if (p < 8) cookie = {cookie[23:0], b};
    else if (p < 12) txn_hi = {txn_hi[23:0], b};
    else if (p < stunrc_pkg::HDR_BYTES) txn_lo = {txn_lo[55:0], b};
    else if (walk == stunrc_pkg::PH_WALKING) begin
      astart = attr_at;
      if (p >= astart && p < astart + 4) begin
        rel = p - astart;
        if (rel < 2) attr_kind = {attr_kind[7:0], b};
        else attr_size = {attr_size[7:0], b};
        if (rel == 3) begin
          stop = stunrc_pkg::HDR_BYTES + msg_len;
          if (astart + 4 > stop || astart + 4 + attr_size > stop) begin
            walk = stunrc_pkg::PH_MISS;
          end else if (attr_kind == stunrc_pkg::ATTR_USER) begin
            if (frag_len > stunrc_pkg::MAX_UFRAG || attr_size <= frag_len)
              walk = stunrc_pkg::PH_MISS;
            else
              walk = stunrc_pkg::PH_MATCHING;
          end else begin
            attr_at = 17'(astart + 4 + ((attr_size + 3) & ~32'd3));
          end
        end
      end
    end else if (walk == stunrc_pkg::PH_MATCHING) begin
      astart = attr_at;
      if (p >= astart + 4) begin
        idx = p - astart - 4;
        if (idx < frag_len) begin
          if (b != frag_char(idx)) chars_ok = 1'b0;
        end else if (idx == frag_len) begin
          colon_ok = (b == stunrc_pkg::CHAR_COLON);
          walk = stunrc_pkg::PH_FOUND;
        end
      end
    end

    if (seen_count != stunrc_pkg::POS_LIMIT) seen_count = seen_count + 17'd1;

    if (last) begin
      count = seen_count;
      if (lead_byte <= 3)
        v.packet_class = stunrc_pkg::CLASS_STUN;
      else if (lead_byte >= 20 && lead_byte <= 63)
        v.packet_class = stunrc_pkg::CLASS_DTLS;
      else if (lead_byte >= 128 && lead_byte <= 191)
        v.packet_class = stunrc_pkg::CLASS_RTP;
      else
        v.packet_class = stunrc_pkg::CLASS_OTHER;
      stop = stunrc_pkg::HDR_BYTES + msg_len;
      fits = (count >= stunrc_pkg::HDR_BYTES) && (stop <= count);
      v.is_binding_request = fits && msg_type == stunrc_pkg::REQ_BINDING &&
                             cookie == stunrc_pkg::COOKIE_MAGIC;
      v.username_matches = fits && walk == stunrc_pkg::PH_FOUND && chars_ok && colon_ok;
      v.transaction_id_high = v.is_binding_request ? txn_hi : '0;
      v.transaction_id_low = v.is_binding_request ? txn_lo : '0;
      awaited_verdicts.push_back(v);
      clear_datagram();
    end
  endtask

  always @(posedge clk) begin : watch
    stunrc_pkg::res_t got, want;
    if (!rst_n) begin
      frag_len = '0;
      frag_lo  = '0;
      frag_hi  = '0;
      clear_datagram();
      awaited_verdicts.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          stunrc_pkg::REG_UFRAG_LEN:  frag_len = cfg_wr_data[4:0];
          stunrc_pkg::REG_CHARS_LOW:  frag_lo = cfg_wr_data;
          stunrc_pkg::REG_CHARS_HIGH: frag_hi = cfg_wr_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {out_packet_class, out_is_binding_request, out_username_matches,
               out_transaction_id_high, out_transaction_id_low};
        if (awaited_verdicts.size() == 0) begin
          $display("%0t: verdict with none awaited: class %0d request %0b match %0b",
                   $time, got.packet_class, got.is_binding_request, got.username_matches);
          fail_tally++;
        end else begin
          want = awaited_verdicts.pop_front();
          if (got !== want) begin
            fail_tally++;
            if (got.packet_class !== want.packet_class)
              $display("%0t: packet_class expected %0d, got %0d",
                       $time, want.packet_class, got.packet_class);
            if (got.is_binding_request !== want.is_binding_request)
              $display("%0t: is_binding_request expected %0b, got %0b",
                       $time, want.is_binding_request, got.is_binding_request);
            if (got.username_matches !== want.username_matches)
              $display("%0t: username_matches expected %0b, got %0b",
                       $time, want.username_matches, got.username_matches);
            if (got.transaction_id_high !== want.transaction_id_high)
              $display("%0t: transaction_id_high expected %h, got %h",
                       $time, want.transaction_id_high, got.transaction_id_high);
            if (got.transaction_id_low !== want.transaction_id_low)
              $display("%0t: transaction_id_low expected %h, got %h",
                       $time, want.transaction_id_low, got.transaction_id_low);
          end
        end
      end
      if (in_valid && !in_stall) take_byte(in_byte_value, in_last_byte);
    end
    failures <= fail_tally;
    awaited <= awaited_verdicts.size();
  end

endmodule

// ----- tb/stun_request_checker_tb.sv -----
`timescale 1ns / 1ps
// Top of the STUN request checker testbench: clock, reset, ufrag settings and
// datagram stimulus with random gaps and output stalls; gives the verdict.
// Depends on stunrc_pkg, stun_request_checker and stun_request_monitor.

module stun_request_checker_tb;

  localparam logic [1:0]  REG_SPARE     = 2'd3;
  localparam int unsigned RANDOM_BYTES  = 650;
  localparam int unsigned MIN_DATAGRAMS = 18;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES  = 8;

  typedef enum {
    FLAW_NONE, FLAW_TYPE, FLAW_COOKIE, FLAW_LENGTH, FLAW_SHORT, FLAW_NAME_EXACT,
    FLAW_NAME_CHAR, FLAW_NAME_SEP, FLAW_OVERRUN, FLAW_TRAILER, FLAW_NO_NAME
  } flaw_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte_value = '0;
  logic        in_last_byte = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  out_packet_class;
  logic        out_is_binding_request;
  logic        out_username_matches;
  logic [31:0] out_transaction_id_high;
  logic [63:0] out_transaction_id_low;
  int unsigned failures;
  int unsigned awaited;

  logic [7:0]  dgram[$];
  logic [7:0]  attr_bytes[$];
  logic [7:0]  attr_value[$];
  logic [7:0]  ufrag_text[16];
  logic [7:0]  class_edges[12] = '{8'd0, 8'd3, 8'd4, 8'd19, 8'd20, 8'd63,
                                   8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
  int unsigned ufrag_size = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned stall_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned dgrams_sent = 0;
  int unsigned settings_used = 0;

  always #1 clk = ~clk;

  stun_request_checker DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_byte_value           (in_byte_value),
    .in_last_byte            (in_last_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_packet_class        (out_packet_class),
    .out_is_binding_request  (out_is_binding_request),
    .out_username_matches    (out_username_matches),
    .out_transaction_id_high (out_transaction_id_high),
    .out_transaction_id_low  (out_transaction_id_low)
  );

  stun_request_monitor verdict_check (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_byte_value           (in_byte_value),
    .in_last_byte            (in_last_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_packet_class        (out_packet_class),
    .out_is_binding_request  (out_is_binding_request),
    .out_username_matches    (out_username_matches),
    .out_transaction_id_high (out_transaction_id_high),
    .out_transaction_id_low  (out_transaction_id_low),
    .failures                (failures),
    .awaited                 (awaited)
  );

  always @(posedge clk) begin : stall_gen
    int unsigned pick;
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (!stalls_on || pick < 60) begin
        out_stall <= 1'b0;
        stall_hold <= $urandom_range(0, 4);
      end else if (pick < 95) begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("stun_request_checker_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] other_type();
    logic [15:0] t;
    t = 16'($urandom_range(0, 65535));
    return (t == stunrc_pkg::ATTR_USER) ? 16'h8022 : t;
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= value;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_dgram();
    for (int k = 0; k < dgram.size(); k++) send_byte(dgram[k], k == dgram.size() - 1);
    dgrams_sent++;
  endtask

  // hold off until every verdict is in, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_ufrag(input logic [4:0] len, input logic [63:0] lo,
                            input logic [63:0] hi);
    logic [63:0] word;
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_wr_data <= {$urandom, $urandom};
    @(posedge clk);
    word = {$urandom, $urandom};
    word[4:0] = len;
    cfg_index <= stunrc_pkg::REG_UFRAG_LEN;
    cfg_wr_data <= word;
    @(posedge clk);
    cfg_index <= stunrc_pkg::REG_CHARS_LOW;
    cfg_wr_data <= lo;
    @(posedge clk);
    cfg_index <= stunrc_pkg::REG_CHARS_HIGH;
    cfg_wr_data <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    for (int k = 0; k < 8; k++) begin
      ufrag_text[k] = lo[63 - 8 * k -: 8];
      ufrag_text[k + 8] = hi[63 - 8 * k -: 8];
    end
    ufrag_size = len;
    settings_used++;
  endtask

  task automatic fill_random(input int unsigned n);
    attr_value.delete();
    repeat (n) attr_value.push_back($urandom_range(0, 255));
  endtask

  // append header, value and padding to the attribute area
  task automatic add_attr(input logic [15:0] kind);
    logic [15:0] len;
    len = attr_value.size();
    attr_bytes.push_back(kind[15:8]);
    attr_bytes.push_back(kind[7:0]);
    attr_bytes.push_back(len[15:8]);
    attr_bytes.push_back(len[7:0]);
    foreach (attr_value[k]) attr_bytes.push_back(attr_value[k]);
    repeat ((4 - len % 4) % 4) attr_bytes.push_back($urandom_range(0, 255));
  endtask

  task automatic build_stun(input flaw_e flaw);
    int unsigned n, k, mlen, keep;
    logic [15:0] mtype, len16;
    logic [31:0] magic;
    attr_bytes.delete();
    repeat ($urandom_range(0, 2)) begin
      fill_random($urandom_range(0, 9));
      add_attr(other_type());
    end
    if (flaw != FLAW_NO_NAME) begin
      n = (ufrag_size > stunrc_pkg::MAX_UFRAG) ? stunrc_pkg::MAX_UFRAG : ufrag_size;
      attr_value.delete();
      for (k = 0; k < n; k++) attr_value.push_back(ufrag_text[k]);
      if (flaw == FLAW_NAME_CHAR && n != 0) begin
        k = $urandom_range(0, n - 1);
        attr_value[k] = attr_value[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      if (flaw != FLAW_NAME_EXACT) begin
        if (flaw == FLAW_NAME_SEP)
          attr_value.push_back(stunrc_pkg::CHAR_COLON ^ (8'h01 << $urandom_range(0, 7)));
        else
          attr_value.push_back(stunrc_pkg::CHAR_COLON);
        repeat ($urandom_range(0, 5)) attr_value.push_back($urandom_range(0, 255));
      end
      add_attr(stunrc_pkg::ATTR_USER);
    end
    if ($urandom_range(0, 3) == 0) begin
      fill_random($urandom_range(0, 6));
      add_attr($urandom_range(0, 1) ? stunrc_pkg::ATTR_USER : other_type());
    end

    mlen = attr_bytes.size();
    if (flaw == FLAW_LENGTH) mlen = mlen + $urandom_range(1, 8);
    if (flaw == FLAW_OVERRUN) begin
      k = $urandom_range(1, 6);
      mlen = (mlen > k) ? mlen - k : 0;
    end
    len16 = 16'(mlen);
    mtype = stunrc_pkg::REQ_BINDING;
    if (flaw == FLAW_TYPE) begin
      mtype = 16'($urandom_range(0, 65535));
      if (mtype == stunrc_pkg::REQ_BINDING) mtype = 16'h0101;
    end
    magic = stunrc_pkg::COOKIE_MAGIC;
    if (flaw == FLAW_COOKIE) magic = magic ^ (32'h1 << $urandom_range(0, 31));

    dgram.delete();
    dgram.push_back(mtype[15:8]);
    dgram.push_back(mtype[7:0]);
    dgram.push_back(len16[15:8]);
    dgram.push_back(len16[7:0]);
    for (k = 0; k < 4; k++) dgram.push_back(magic[31 - 8 * k -: 8]);
    repeat (12) dgram.push_back($urandom_range(0, 255));
    foreach (attr_bytes[j]) dgram.push_back(attr_bytes[j]);
    if (flaw == FLAW_SHORT) begin
      keep = $urandom_range(1, stunrc_pkg::HDR_BYTES - 1);
      while (dgram.size() > keep) void'(dgram.pop_back());
    end
    if (flaw == FLAW_TRAILER || flaw == FLAW_NO_NAME)
      repeat ($urandom_range(1, 8)) dgram.push_back($urandom_range(0, 255));
  endtask

  task automatic build_noise();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
    dgram.delete();
    repeat (n) dgram.push_back($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: dgram[0] = $urandom_range(0, 3);
      1: dgram[0] = $urandom_range(20, 63);
      2: dgram[0] = $urandom_range(128, 191);
      default: ;
    endcase
  endtask

  initial begin
    int unsigned phase, base_bytes, base_dgrams;
    flaw_e flaw;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: empty ufrag, so only the colon counts
    foreach (class_edges[k]) begin
      dgram.delete();
      dgram.push_back(class_edges[k]);
      send_dgram();
    end
    build_stun(FLAW_NONE);
    send_dgram();
    settle();

    load_ufrag(5'd4, {"wxyz", $urandom}, {$urandom, $urandom});
    for (int f = FLAW_NONE; f <= FLAW_NO_NAME; f++) begin
      build_stun(flaw_e'(f));
      send_dgram();
    end
    settle();

    base_bytes = bytes_sent;
    base_dgrams = dgrams_sent;
    for (phase = 0; bytes_sent - base_bytes < RANDOM_BYTES ||
                    dgrams_sent - base_dgrams < MIN_DATAGRAMS; phase++) begin
      case (phase % 6)
        0: load_ufrag(5'd16, '1, '1);
        1: load_ufrag(5'd0, '0, '0);
        2: load_ufrag(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
        3: load_ufrag(5'($urandom_range(17, 30)), {$urandom, $urandom},
                      {$urandom, $urandom});
        default: load_ufrag(5'($urandom_range(1, 16)), {$urandom, $urandom},
                            {$urandom, $urandom});
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on <= ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 9) < 7) begin
          flaw = ($urandom_range(0, 9) < 4) ? FLAW_NONE
                                             : flaw_e'($urandom_range(1, FLAW_NO_NAME));
          build_stun(flaw);
        end else begin
          build_noise();
        end
        send_dgram();
      end
      settle();
    end

    $display("covered %0d datagrams, %0d bytes, %0d ufrag settings",
             dgrams_sent, bytes_sent, settings_used);
    $display("including all class edges, every request flaw and out-of-range ufrag lengths");
    if (failures == 0) begin
      $display("stun_request_checker_tb: clean");
    end else begin
      $display("stun_request_checker_tb: errors");
    end
    $finish;
  end

endmodule
